>>> sv/qif_pkg.sv
`default_nettype none

package qif_pkg;

  // Table geometry.
  localparam int NEURONS   = 1024;
  localparam int IDX_W     = 10;
  localparam int MAX_STEPS = 64;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = 70;

  // Fixed-point constants.
  localparam logic signed [32:0] ONE_Q24   = 33'sd16777216;
  localparam logic [32:0]        RECIP_SIX = 33'd5726623061;  // floor(2^35 / 6)
  localparam logic signed [MUL_PW-1:0] WIDE_MAX = 70'sd2147483647;
  localparam logic signed [MUL_PW-1:0] WIDE_MIN = -70'sd2147483648;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_STEP   = 2'd1,
    REG_COUNT  = 2'd2,
    REG_THRESH = 2'd3
  } cfg_reg_t;

  // Item modes.
  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_DRIVE,
    ST_SQ,
    ST_AP,
    ST_KH,
    ST_KS,
    ST_DIV,
    ST_CORR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                mode;
    logic [IDX_W-1:0]    neuron_index;
    logic signed [31:0]  load_scale;
    logic signed [31:0]  load_potential;
    logic signed [31:0]  excitatory_current;
    logic signed [31:0]  inhibitory_current;
    logic signed [31:0]  external_current;
    logic                forced_fire;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    result_index;
    logic                spiked;
    logic signed [31:0]  new_potential;
    logic [63:0]         spike_history;
  } out_item_t;

  typedef struct packed {
    logic [23:0]         current_gain;
    logic [23:0]         step_size;
    logic [6:0]          substep_count;
    logic signed [31:0]  fire_threshold;
  } cfg_t;

  // One neuron table row.
  typedef struct packed {
    logic [63:0]         hist;
    logic signed [31:0]  scale;
    logic signed [31:0]  pot;
  } row_t;

  // Table access request from the sequencer.
  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    addr;
    row_t                wdata;
  } tbl_req_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [MUL_PW-1:0] x);
    logic signed [31:0] r;
    if (x > WIDE_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < WIDE_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/qif_mul.sv
`default_nettype none

module qif_mul (
  input  wire logic                              clk,
  input  wire logic signed [qif_pkg::MUL_AW-1:0] op_a,
  input  wire logic signed [qif_pkg::MUL_BW-1:0] op_b,
  output logic signed [qif_pkg::MUL_PW-1:0]      prod
);
  import qif_pkg::*;

  // Registered signed product, shared by every multiply of the sequencer.
  always_ff @(posedge clk) begin
    prod <= MUL_PW'(op_a) * MUL_PW'(op_b);
  end

endmodule

`default_nettype wire

>>> sv/qif_table.sv
`default_nettype none

module qif_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qif_pkg::tbl_req_t req,
  output qif_pkg::row_t          rdata,
  output logic                   busy
);
  import qif_pkg::*;

  row_t             mem [NEURONS];
  logic             clr_r;
  logic             clr_nxt;
  logic [IDX_W-1:0] clr_addr_r;
  logic [IDX_W-1:0] clr_addr_nxt;

  // Clearing pass walks the table once after reset.
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == IDX_W'(NEURONS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

  assign busy = clr_r;

endmodule

`default_nettype wire

>>> sv/qif_seq.sv
`default_nettype none

module qif_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qif_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire qif_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output qif_pkg::out_item_t     out_data,
  output qif_pkg::tbl_req_t      tbl_req,
  input  wire qif_pkg::row_t     tbl_rdata,
  input  wire logic              tbl_busy
);
  import qif_pkg::*;

  state_t                    state_r, state_nxt;
  in_item_t                  item_r, item_nxt;
  logic signed [31:0]        v_r, v_nxt;
  logic signed [31:0]        a_r, a_nxt;
  logic [63:0]               hist_r, hist_nxt;
  logic signed [31:0]        drive_r, drive_nxt;
  logic signed [34:0]        ksum_r, ksum_nxt;
  logic [33:0]               n_r, n_nxt;
  logic                      qneg_r, qneg_nxt;
  logic [31:0]               d_r, d_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic [6:0]                cnt_r, cnt_nxt;
  logic [6:0]                steps_r, steps_nxt;
  logic                      fired_r, fired_nxt;
  logic signed [MUL_AW-1:0]  op_a_nxt;
  logic signed [MUL_BW-1:0]  op_b_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic signed [MUL_PW-1:0]  prod;
  logic                      in_xfer;
  logic                      finish_go;
  logic signed [33:0]        cur_sum;
  logic signed [31:0]        p_val;
  logic signed [31:0]        k_val;
  logic signed [MUL_PW-1:0]  kh_term;
  logic signed [31:0]        x_val;
  logic signed [34:0]        ksum_add;
  logic signed [34:0]        q_val;
  logic [33:0]               n_val;
  logic [31:0]               e_val;
  logic [34:0]               six_e;
  logic [34:0]               rem;
  logic [31:0]               d_val;
  logic signed [32:0]        ds;
  logic signed [31:0]        v_new;
  logic                      fire_now;
  logic signed [32:0]        v_m1;
  logic signed [32:0]        x_m1;
  logic signed [32:0]        vn_m1;
  logic                      fin_fire;
  logic [63:0]               fin_hist;
  logic signed [31:0]        fin_pot;
  logic signed [MUL_BW-1:0]  h_op;

  // Operands chosen in one state give their product in the next state.
  qif_mul u_mul (
    .clk  (clk),
    .op_a (op_a_nxt),
    .op_b (op_b_nxt),
    .prod (prod)
  );

  assign in_stall  = (state_r != ST_IDLE) || tbl_busy;
  assign in_xfer   = in_valid && !in_stall;
  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Arithmetic around the shared multiplier.
  always_comb begin
    cur_sum  = 34'(item_r.excitatory_current) + 34'(item_r.inhibitory_current)
             + 34'(item_r.external_current);
    h_op     = MUL_BW'({1'b0, cfg.step_size});
    p_val    = sat32(prod >>> 24);
    k_val    = sat32((prod >>> 24) + MUL_PW'(drive_r));
    kh_term  = (phase_r < 2'd2) ? (prod >>> 25) : (prod >>> 24);
    x_val    = sat32(MUL_PW'(v_r) + kh_term);
    case (phase_r)
      2'd0:    ksum_add = 35'(k_val);
      2'd3:    ksum_add = ksum_r + 35'(k_val);
      default: ksum_add = ksum_r + (35'(k_val) <<< 1);
    endcase
    q_val    = prod[58:24];
    n_val    = q_val[34] ? ~q_val[33:0] : q_val[33:0];
    e_val    = prod[66:35];
    six_e    = ({3'b000, e_val} << 2) + ({3'b000, e_val} << 1);
    rem      = {1'b0, n_r} - six_e;
    d_val    = (rem >= 35'd6) ? (e_val + 32'd1) : e_val;
    ds       = qneg_r ? ~{1'b0, d_r} : {1'b0, d_r};
    v_new    = sat32(MUL_PW'(v_r) + MUL_PW'(ds));
    fire_now = v_new >= $signed(cfg.fire_threshold);
    v_m1     = 33'(v_r) - ONE_Q24;
    x_m1     = 33'(x_val) - ONE_Q24;
    vn_m1    = 33'(v_new) - ONE_Q24;
    fin_fire = fired_r || ((item_r.mode == MODE_UPDATE) && item_r.forced_fire);
    fin_hist = (item_r.mode == MODE_UPDATE) ? {hist_r[62:0], fin_fire} : hist_r;
    fin_pot  = fin_fire ? 32'sd0 : v_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) begin
        state_nxt = ST_READ;
      end
      ST_READ:   state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = (item_r.mode == MODE_UPDATE) ? ST_DRIVE : ST_FINISH;
      ST_DRIVE:  state_nxt = (steps_r == 7'd0) ? ST_FINISH : ST_SQ;
      ST_SQ:     state_nxt = ST_AP;
      ST_AP:     state_nxt = (phase_r == 2'd3) ? ST_KS : ST_KH;
      ST_KH:     state_nxt = ST_SQ;
      ST_KS:     state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_CORR;
      ST_CORR:   state_nxt = (fire_now || (cnt_r + 7'd1 == steps_r)) ? ST_FINISH : ST_SQ;
      ST_FINISH: if (finish_go) begin
        state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath register updates and table requests per state.
  always_comb begin
    item_nxt      = item_r;
    v_nxt         = v_r;
    a_nxt         = a_r;
    hist_nxt      = hist_r;
    drive_nxt     = drive_r;
    ksum_nxt      = ksum_r;
    n_nxt         = n_r;
    qneg_nxt      = qneg_r;
    d_nxt         = d_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    fired_nxt     = fired_r;
    op_a_nxt      = '0;
    op_b_nxt      = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tbl_req       = '0;
    tbl_req.addr  = item_r.neuron_index;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          item_nxt = in_data;
        end
      end
      ST_READ: begin
        tbl_req.rd_en = 1'b1;
      end
      ST_FETCH: begin
        fired_nxt = 1'b0;
        cnt_nxt   = '0;
        steps_nxt = (cfg.substep_count > 7'(MAX_STEPS)) ? 7'(MAX_STEPS)
                                                       : cfg.substep_count;
        hist_nxt  = tbl_rdata.hist;
        if (item_r.mode == MODE_UPDATE) begin
          v_nxt = tbl_rdata.pot;
          a_nxt = tbl_rdata.scale;
        end else begin
          v_nxt = item_r.load_potential;
          a_nxt = item_r.load_scale;
        end
        op_a_nxt = MUL_AW'(cur_sum);
        op_b_nxt = MUL_BW'({1'b0, cfg.current_gain});
      end
      ST_DRIVE: begin
        drive_nxt = sat32(prod >>> 16);
        phase_nxt = '0;
        op_a_nxt  = MUL_AW'(v_r);
        op_b_nxt  = MUL_BW'(v_m1);
      end
      ST_SQ: begin
        op_a_nxt = MUL_AW'(a_r);
        op_b_nxt = MUL_BW'(p_val);
      end
      ST_AP: begin
        ksum_nxt = ksum_add;
        op_b_nxt = h_op;
        if (phase_r == 2'd3) begin
          op_a_nxt = MUL_AW'(ksum_add);
        end else begin
          op_a_nxt = MUL_AW'(k_val);
        end
      end
      ST_KH: begin
        phase_nxt = phase_r + 2'd1;
        op_a_nxt  = MUL_AW'(x_val);
        op_b_nxt  = MUL_BW'(x_m1);
      end
      ST_KS: begin
        n_nxt    = n_val;
        qneg_nxt = q_val[34];
        op_a_nxt = MUL_AW'({2'b00, n_val});
        op_b_nxt = MUL_BW'({1'b0, RECIP_SIX});
      end
      ST_DIV: begin
        d_nxt = d_val;
      end
      ST_CORR: begin
        v_nxt     = v_new;
        fired_nxt = fire_now;
        cnt_nxt   = cnt_r + 7'd1;
        phase_nxt = '0;
        op_a_nxt  = MUL_AW'(v_new);
        op_b_nxt  = MUL_BW'(vn_m1);
      end
      ST_FINISH: begin
        if (finish_go) begin
          tbl_req.wr_en              = 1'b1;
          tbl_req.wdata.hist         = fin_hist;
          tbl_req.wdata.scale        = a_r;
          tbl_req.wdata.pot          = fin_pot;
          out_valid_nxt              = 1'b1;
          out_data_nxt.result_index  = item_r.neuron_index;
          out_data_nxt.spiked        = fin_fire;
          out_data_nxt.new_potential = fin_pot;
          out_data_nxt.spike_history = fin_hist;
        end
      end
      default: begin
        tbl_req = '0;
      end
    endcase
  end

  // Control registers reset; payload registers just follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    v_r        <= v_nxt;
    a_r        <= a_nxt;
    hist_r     <= hist_nxt;
    drive_r    <= drive_nxt;
    ksum_r     <= ksum_nxt;
    n_r        <= n_nxt;
    qneg_r     <= qneg_nxt;
    d_r        <= d_nxt;
    phase_r    <= phase_nxt;
    cnt_r      <= cnt_nxt;
    steps_r    <= steps_nxt;
    fired_r    <= fired_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sv/qif_neuron_rk4_update.sv
// Quadratic integrate-and-fire neuron table with RK4 integration.
// Input channel (in_valid / in_stall / in_data): one item either loads a
// neuron's potential and scale or updates one neuron. A transfer happens when
// in_valid is high and in_stall is low. Each item gives exactly one result on
// the output channel (out_valid / out_stall / out_data).
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets gain, step
// size, substep count and threshold; cfg_ready is always high.
// Sequencing: a load reads the table row and goes straight to the result. An
// update runs RK4 substeps, up to the substep count (capped at 64) and
// fewer if the neuron crosses threshold early. All multiplies go through one
// registered multiplier, one per cycle. One item is in flight at a time; the
// next item is taken once the result has moved to the output register, even
// if the receiver still stalls it.
// Reset: after rst_n is released the table is cleared over 1024 cycles, during
// which in_stall stays high. A stalled result holds on out_data until taken.

`default_nettype none

module qif_neuron_rk4_update (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire qif_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qif_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire qif_pkg::cfg_reg_t  cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import qif_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  tbl_req_t tbl_req;
  row_t     tbl_rdata;
  logic     tbl_busy;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:   cfg_nxt.current_gain   = cfg_data[23:0];
        REG_STEP:   cfg_nxt.step_size      = cfg_data[23:0];
        REG_COUNT:  cfg_nxt.substep_count  = cfg_data[6:0];
        REG_THRESH: cfg_nxt.fire_threshold = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_gain   <= 24'd251658;
      cfg_r.step_size      <= 24'd1677722;
      cfg_r.substep_count  <= 7'd10;
      cfg_r.fire_threshold <= 32'sd16777216;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qif_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rdata (tbl_rdata),
    .busy  (tbl_busy)
  );

  qif_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata),
    .tbl_busy  (tbl_busy)
  );

endmodule

`default_nettype wire

>>> sv/qif_checker.sv
`default_nettype none

module qif_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire qif_pkg::out_item_t out_data
);
  import qif_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The table is being cleared right after reset.
  a_clear_stall: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_stall)
    else $error("input taken during clearing pass");

  // A firing neuron reports zero potential and a set newest history bit.
  a_spike_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.spiked |->
      (out_data.new_potential == 32'sd0) && out_data.spike_history[0])
    else $error("spike result inconsistent");

endmodule

bind qif_neuron_rk4_update qif_checker u_qif_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/tb_qif_neuron_rk4_update.sv
`default_nettype none

module tb_qif_neuron_rk4_update;
  timeunit 1ns;
  timeprecision 1ps;

  import qif_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  cfg_reg_t cfg_index;
  logic [31:0] cfg_data;

  qif_neuron_rk4_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the neuron table and the settings.
  logic signed [31:0] pot_tbl [NEURONS];
  logic signed [31:0] scale_tbl [NEURONS];
  logic [63:0] hist_tbl [NEURONS];
  logic [23:0] gain_q;
  logic [23:0] step_q;
  logic [6:0] count_q;
  logic signed [31:0] thresh_q;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int error_count;
  int idle_cycles;
  bit hold_sender;
  bit long_hold_req;
  int long_hold_left;
  int burst_left;
  int gap_left;
  int stall_mode;

  // Floor division of a wide signed value by a power of two.
  function automatic logic signed [127:0] floor_shr(input logic signed [127:0] x,
                                                  input int sh);
    return x >>> sh;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] slope(input logic signed [31:0] a,
                                               input logic signed [31:0] x,
                                               input logic signed [31:0] drive);
    logic signed [127:0] xw;
    logic signed [127:0] p;
    xw = x;
    p = clamp32(floor_shr(xw * (xw - 128'sd16777216), 24));
    return clamp32(floor_shr($signed(128'(a)) * p, 24) + drive);
  endfunction

  // Predicts the result of one item and updates the shadow table.
  function automatic out_item_t predict_neuron(input in_item_t it);
    out_item_t r;
    logic signed [127:0] sum, h, ks, q;
    logic signed [31:0] drive, a, v, k1, k2, k3, k4, x2, x3, x4;
    int steps;
    bit fired;
    int idx;
    idx = it.neuron_index;
    r = '0;
    r.result_index = it.neuron_index;
    fired = 0;
    if (it.mode == MODE_LOAD) begin
      scale_tbl[idx] = it.load_scale;
      pot_tbl[idx] = it.load_potential;
      v = it.load_potential;
    end else begin
      sum = $signed(128'(it.excitatory_current)) + it.inhibitory_current
            + it.external_current;
      drive = clamp32(floor_shr(sum * $signed({104'd0, gain_q}), 16));
      a = scale_tbl[idx];
      h = $signed({104'd0, step_q});
      steps = (count_q > 64) ? 64 : count_q;
      v = pot_tbl[idx];
      for (int t = 0; t < steps && !fired; t++) begin
        k1 = slope(a, v, drive);
        x2 = clamp32(v + floor_shr(k1 * h, 25));
        k2 = slope(a, x2, drive);
        x3 = clamp32(v + floor_shr(k2 * h, 25));
        k3 = slope(a, x3, drive);
        x4 = clamp32(v + floor_shr(k3 * h, 24));
        k4 = slope(a, x4, drive);
        ks = $signed(128'(k1)) + 2 * $signed(128'(k2)) + 2 * $signed(128'(k3)) + k4;
        // Floor division by 6 * 2^24.
        q = ks * h;
        if (q >= 0) q = q / (6 * 128'sd16777216);
        else q = -((-(q + 1)) / (6 * 128'sd16777216)) - 1;
        v = clamp32(v + q);
        fired = (v >= thresh_q);
      end
      if (it.forced_fire) fired = 1;
      hist_tbl[idx] = {hist_tbl[idx][62:0], fired};
      if (fired) v = 0;
      pot_tbl[idx] = v;
    end
    r.spiked = fired;
    r.new_potential = v;
    r.spike_history = hist_tbl[idx];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Clock generator.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && in_stall) begin
      // Hold the offered item.
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_neuron(in_data));
        void'(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (burst_left == 0 && $urandom_range(0, 3) == 0) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= $urandom_range(0, 8);
        in_valid <= 0;
      end else if (!hold_sender && pending_items.size() > 0) begin
        in_valid <= 1;
        in_data <= pending_items[0];
        if (burst_left > 0) burst_left <= burst_left - 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      long_hold_left <= 0;
      stall_mode <= 0;
    end else begin
      if (long_hold_req && long_hold_left == 0) long_hold_left <= 600;
      else if (long_hold_left > 1) long_hold_left <= long_hold_left - 1;
      else if (long_hold_left == 1) long_hold_left <= 0;
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= (long_hold_left > 1);
        1: out_stall <= (long_hold_left > 1) || ($urandom_range(0, 3) == 0);
        default: out_stall <= (long_hold_left > 1) || ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Monitor: compares each transferred result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.result_index, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_index !== want.result_index)
          report_mismatch("result_index", out_data.result_index, want.result_index);
        if (out_data.spiked !== want.spiked)
          report_mismatch("spiked", out_data.spiked, want.spiked);
        if (out_data.new_potential !== want.new_potential)
          report_mismatch("new_potential", out_data.new_potential, want.new_potential);
        if (out_data.spike_history !== want.spike_history)
          report_mismatch("spike_history", out_data.spike_history, want.spike_history);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_qif_neuron_rk4_update: errors");
        $finish;
      end
    end
  end

  // Waits until every queued item is sent and every result has arrived.
  task automatic drain;
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_GAIN: gain_q = val[23:0];
      REG_STEP: step_q = val[23:0];
      REG_COUNT: count_q = val[6:0];
      default: thresh_q = val;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom();
    endcase
  endfunction

  // Potential and scale near the interesting range of a Q8.24 neuron.
  function automatic logic [31:0] rand_q24();
    if ($urandom_range(0, 4) == 0) return rand_word();
    return $signed($urandom_range(0, 67108863)) - 33554432;
  endfunction

  function automatic in_item_t make_item(input bit m, input int idx, input bit wild);
    in_item_t it;
    it.mode = m ? MODE_UPDATE : MODE_LOAD;
    it.neuron_index = IDX_W'(idx);
    it.load_scale = rand_q24();
    it.load_potential = rand_q24();
    it.excitatory_current = wild ? rand_word() : $urandom_range(0, 8388607);
    it.inhibitory_current = wild ? rand_word() : -$signed($urandom_range(0, 4194303));
    it.external_current = wild ? rand_word() : $urandom_range(0, 4194303);
    it.forced_fire = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  task automatic random_phase(input int n);
    int base;
    base = $urandom_range(0, 1015);
    for (int i = 0; i < n; i++) begin
      // Mostly updates on a few neurons so histories grow; some loads and wide spread.
      if ($urandom_range(0, 4) == 0)
        pending_items.push_back(make_item(0, base + $urandom_range(0, 7), 0));
      else if ($urandom_range(0, 9) == 0)
        pending_items.push_back(make_item($urandom_range(0, 1), $urandom_range(0, 1023),
                                          1));
      else
        pending_items.push_back(make_item(1, base + $urandom_range(0, 7),
                                          $urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    in_item_t it;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = REG_GAIN;
    cfg_data = 0;
    in_data = '0;
    hold_sender = 0;
    long_hold_req = 0;
    error_count = 0;
    for (int n = 0; n < NEURONS; n++) begin
      pot_tbl[n] = 0;
      scale_tbl[n] = 0;
      hist_tbl[n] = 0;
    end
    gain_q = 24'd251658;
    step_q = 24'd1677722;
    count_q = 7'd10;
    thresh_q = 32'sd16777216;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Directed: loads, updates at field extremes, forced fire, both ends of the table.
    pending_items.push_back(make_item(1, 0, 0));
    it = make_item(0, 1023, 0);
    it.load_scale = 32'sh80000000; it.load_potential = 32'sh7fffffff;
    pending_items.push_back(it);
    it = make_item(1, 1023, 0);
    it.excitatory_current = 32'sh7fffffff; it.inhibitory_current = 32'sh7fffffff;
    it.external_current = 32'sh7fffffff; it.forced_fire = 0;
    pending_items.push_back(it);
    it = make_item(0, 5, 0);
    it.load_scale = 32'sh7fffffff; it.load_potential = 32'sh80000000;
    pending_items.push_back(it);
    it = make_item(1, 5, 0);
    it.excitatory_current = 32'sh80000000; it.inhibitory_current = 32'sh80000000;
    it.external_current = 32'sh80000000; it.forced_fire = 1;
    pending_items.push_back(it);
    it = make_item(0, 7, 0);
    it.load_scale = 32'sh01000000; it.load_potential = 32'sh00800000;
    pending_items.push_back(it);
    for (int i = 0; i < 6; i++) begin
      it = make_item(1, 7, 0);
      it.forced_fire = (i == 2);
      pending_items.push_back(it);
    end
    it = make_item(0, 7, 0);
    pending_items.push_back(it);
    it = make_item(1, 7, 1);
    it.load_scale = 32'sh7fffffff; it.load_potential = 32'sh80000000;
    it.forced_fire = 0;
    pending_items.push_back(it);
    drain();

    // Settings sweep, with random traffic under each.
    write_reg(REG_COUNT, 0);
    write_reg(REG_GAIN, 24'hffffff);
    random_phase(20);
    drain();
    write_reg(REG_COUNT, 64);
    write_reg(REG_STEP, 24'hffffff);
    write_reg(REG_THRESH, 32'sh7fffffff);
    random_phase(15);
    drain();
    write_reg(REG_COUNT, 127);
    write_reg(REG_THRESH, 32'sh80000000);
    write_reg(REG_GAIN, 0);
    write_reg(REG_STEP, 0);
    random_phase(20);
    drain();
    write_reg(REG_COUNT, 1);
    write_reg(REG_GAIN, 24'd251658);
    write_reg(REG_STEP, 24'd1677722);
    write_reg(REG_THRESH, 32'sd16777216);
    random_phase(60);
    drain();

    // Long receiver hold-off while the sender keeps offering items.
    write_reg(REG_COUNT, 3);
    long_hold_req = 1;
    random_phase(30);
    repeat (2) @(posedge clk);
    long_hold_req = 0;
    drain();

    // Sender pauses with items queued while the block is empty, then resumes.
    write_reg(REG_COUNT, 10);
    hold_sender = 1;
    random_phase(40);
    repeat (30) @(posedge clk);
    hold_sender = 0;
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_GAIN, $urandom_range(0, 24'hffffff));
      write_reg(REG_STEP, $urandom_range(0, 24'h3fffff));
      write_reg(REG_COUNT, $urandom_range(1, 20));
      write_reg(REG_THRESH, $signed($urandom_range(0, 67108863)) - 16777216);
      random_phase(45);
      drain();
    end

    if (error_count == 0) begin
      $display("tb_qif_neuron_rk4_update: clean");
    end else begin
      $display("tb_qif_neuron_rk4_update: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
